### rtl/tst_pkg.sv
`default_nettype none

package tst_pkg;

	// field and state widths
	localparam int COUNT_BITS = 32;
	localparam int TEMP_BITS  = 18;
	localparam int SUM_W      = TEMP_BITS + COUNT_BITS;
	localparam int CRIT_W     = 17;
	localparam int RPM_W      = 16;
	localparam int PCT_W      = 7;
	localparam int STAT_W     = 2;
	localparam int FAN_PROD_W = RPM_W + PCT_W;

	// shared divider geometry
	localparam int DIV_W  = (COUNT_BITS > RPM_W) ? COUNT_BITS : RPM_W;
	localparam int DIVD_W = (SUM_W > FAN_PROD_W) ? SUM_W : FAN_PROD_W;
	localparam int QUO_W  = TEMP_BITS;
	localparam int QCNT_W = $clog2(QUO_W + 1);

	// threshold compare: magnitude of a non-negative temperature times 100
	localparam int MAG_W = TEMP_BITS - 1;
	localparam int CMP_W = ((MAG_W > CRIT_W) ? MAG_W : CRIT_W) + 7;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CRIT_W;

	localparam logic [CRIT_W-1:0] CRIT_RESET    = CRIT_W'(100000);
	localparam logic [RPM_W-1:0]  FAN_MAX_RESET = RPM_W'(5000);
	localparam logic [PCT_W-1:0]  PCT_FULL      = PCT_W'(100);
	localparam logic [CMP_W-1:0]  WARN_TEMP_MUL = CMP_W'(100);
	localparam logic [CMP_W-1:0]  WARN_CRIT_MUL = CMP_W'(85);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRITICAL    = 2'd0,
		REG_FAN_PRESENT = 2'd1,
		REG_FAN_MAX     = 2'd2
	} cfg_reg_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_WARN = 2'd1,
		STAT_CRIT = 2'd2,
		STAT_ERR  = 2'd3
	} status_t;

	typedef enum logic {
		DIV_MEAN = 1'b0,
		DIV_FAN  = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     update;
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_capture;
		logic     fan_capture;
		logic     push;
	} tst_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic fan_div;
		logic div_busy;
		logic div_done;
	} tst_sts_t;

endpackage

`default_nettype wire

### rtl/tst_smp_if.sv
`default_nettype none

interface tst_smp_if import tst_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        sample_ok;
	logic signed [TEMP_BITS-1:0] temp_mdeg;
	logic                        fan_ok;
	logic        [RPM_W-1:0]     fan_rpm;

	modport source (output valid, sample_ok, temp_mdeg, fan_ok, fan_rpm, input ready);
	modport sink   (input valid, sample_ok, temp_mdeg, fan_ok, fan_rpm, output ready);
endinterface

`default_nettype wire

### rtl/tst_res_if.sv
`default_nettype none

interface tst_res_if import tst_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        active;
	logic        [STAT_W-1:0]    status;
	logic signed [TEMP_BITS-1:0] current_milli;
	logic signed [TEMP_BITS-1:0] min_milli;
	logic signed [TEMP_BITS-1:0] max_milli;
	logic signed [TEMP_BITS-1:0] mean_milli;
	logic        [PCT_W-1:0]     fan_percent;

	modport source (output valid, active, status, current_milli, min_milli, max_milli,
		mean_milli, fan_percent, input ready);
	modport sink   (input valid, active, status, current_milli, min_milli, max_milli,
		mean_milli, fan_percent, output ready);
endinterface

`default_nettype wire

### rtl/temperature_sample_tracker_unit.sv
`default_nettype none

// Temperature sample tracker. Each request on smp carries one temperature
// read (signed millidegrees, with a read-ok flag) and one fan speed read;
// each request yields exactly one result on res with the tracker's state:
// active flag, status (ok / warn / critical / error), current, min, max and
// mean temperature, and fan percent. A failed temperature read only drops
// the active flag. A good read updates current/min/max (the first good read
// seeds both), adds into a 50-bit running sum over a 32-bit count (both
// freeze once the count saturates) and recomputes status against
// critical_milli: negative is error, at or above critical is critical,
// 100*temp >= 85*critical is warn. With a fan present, fan percent is
// rpm*100/fan_full_rpm capped at 100, or 0 on a failed fan read or a zero
// rpm or full scale. One shared restoring divider does the mean and
// the fan ratio. The mean division is skipped while no good sample exists,
// the fan division when the ratio is settled without it. One request is
// worked on at a time; a finished result sits in an output register, so the
// next request is accepted while it waits. Configuration registers
// (0: critical_milli, 1: fan_present, 2: fan_full_rpm) are written through
// cfg_we/cfg_idx/cfg_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce; index 3 is ignored.
module temperature_sample_tracker_unit import tst_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	tst_smp_if.sink                    smp,
	tst_res_if.source                  res
);

	tst_cmd_t cmd;   // controller -> datapath
	tst_sts_t sts;   // datapath -> controller

	// sequencer: accept, update, mean division, fan division, result load
	tst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp.valid),
		.in_ready  (smp.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// config, tracker state, shared divider and the result register
	tst_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.sample_ok     (smp.sample_ok),
		.temp_mdeg     (smp.temp_mdeg),
		.fan_ok        (smp.fan_ok),
		.fan_rpm       (smp.fan_rpm),
		.cmd           (cmd),
		.sts           (sts),
		.active        (res.active),
		.status        (res.status),
		.current_milli (res.current_milli),
		.min_milli     (res.min_milli),
		.max_milli     (res.max_milli),
		.mean_milli    (res.mean_milli),
		.fan_percent   (res.fan_percent)
	);

endmodule

`default_nettype wire

### rtl/tst_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; caller guarantees
// (dividend >> QUO_W) < divisor so the quotient fits QUO_W bits
module tst_div import tst_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output logic                   busy,
	output logic                   done,
	output logic      [QUO_W-1:0]  quotient
);

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dsr_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, dvd_q[QUO_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
		rem_n = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_W'(dividend >> QUO_W);
			dvd_q <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

### rtl/tst_datapath.sv
`default_nettype none

module tst_datapath import tst_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic        [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic        [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                        sample_ok,
	input  wire logic signed [TEMP_BITS-1:0] temp_mdeg,
	input  wire logic                        fan_ok,
	input  wire logic        [RPM_W-1:0]     fan_rpm,
	input  wire tst_cmd_t                    cmd,
	output tst_sts_t                         sts,
	output logic                             active,
	output logic             [STAT_W-1:0]    status,
	output logic signed      [TEMP_BITS-1:0] current_milli,
	output logic signed      [TEMP_BITS-1:0] min_milli,
	output logic signed      [TEMP_BITS-1:0] max_milli,
	output logic signed      [TEMP_BITS-1:0] mean_milli,
	output logic             [PCT_W-1:0]     fan_percent
);

	// configuration
	logic [CRIT_W-1:0] crit_q;
	logic              fan_pres_q;
	logic [RPM_W-1:0]  fan_max_q;

	// captured request
	logic                        ok_q;
	logic signed [TEMP_BITS-1:0] temp_q;
	logic                        fok_q;
	logic        [RPM_W-1:0]     rpm_q;

	// tracker state
	logic                        active_q;
	status_t                     status_q;
	logic signed [TEMP_BITS-1:0] cur_q;
	logic signed [TEMP_BITS-1:0] min_q;
	logic signed [TEMP_BITS-1:0] max_q;
	logic        [SUM_W-1:0]     sum_q;
	logic        [COUNT_BITS-1:0] cnt_q;
	logic        [TEMP_BITS-1:0] mean_q;
	logic        [PCT_W-1:0]     fan_pct_q;

	// result register
	logic                        res_active_q;
	logic        [STAT_W-1:0]    res_status_q;
	logic signed [TEMP_BITS-1:0] res_cur_q;
	logic signed [TEMP_BITS-1:0] res_min_q;
	logic signed [TEMP_BITS-1:0] res_max_q;
	logic signed [TEMP_BITS-1:0] res_mean_q;
	logic        [PCT_W-1:0]     res_fan_q;

	logic                  fan_valid;
	logic                  rpm_full;
	logic                  cnt_full;
	logic [MAG_W-1:0]      tmag;
	logic [CMP_W-1:0]      t_scaled;
	logic [CMP_W-1:0]      c_scaled;
	status_t               status_n;
	logic [SUM_W-1:0]      sum_mag;
	logic [FAN_PROD_W-1:0] fan_prod;
	logic [DIVD_W-1:0]     div_dividend;
	logic [DIV_W-1:0]      div_divisor;
	logic                  div_busy;
	logic                  div_done;
	logic [QUO_W-1:0]      div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q     <= CRIT_RESET;
			fan_pres_q <= 1'b0;
			fan_max_q  <= FAN_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CRITICAL:    crit_q     <= cfg_wdata[CRIT_W-1:0];
				REG_FAN_PRESENT: fan_pres_q <= cfg_wdata[0];
				REG_FAN_MAX:     fan_max_q  <= cfg_wdata[RPM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ok_q   <= sample_ok;
			temp_q <= temp_mdeg;
			fok_q  <= fan_ok;
			rpm_q  <= fan_rpm;
		end
	end

	always_comb begin
		fan_valid = fok_q && (rpm_q != '0) && (fan_max_q != '0);
		rpm_full  = (rpm_q >= fan_max_q);
		cnt_full  = &cnt_q;
		tmag      = temp_q[MAG_W-1:0];
		t_scaled  = CMP_W'(tmag) * WARN_TEMP_MUL;
		c_scaled  = CMP_W'(crit_q) * WARN_CRIT_MUL;
		if (temp_q[TEMP_BITS-1])
			status_n = STAT_ERR;
		else if (CMP_W'(tmag) >= CMP_W'(crit_q))
			status_n = STAT_CRIT;
		else if (t_scaled >= c_scaled)
			status_n = STAT_WARN;
		else
			status_n = STAT_OK;
	end

	// state that resets to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			status_q  <= STAT_OK;
			cur_q     <= '0;
			min_q     <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			mean_q    <= '0;
			fan_pct_q <= '0;
		end else begin
			if (cmd.update) begin
				if (!ok_q) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					cur_q    <= temp_q;
					status_q <= status_n;
					if (cnt_q == '0) begin
						min_q <= temp_q;
						max_q <= temp_q;
					end else begin
						if (temp_q > max_q)
							max_q <= temp_q;
						if (temp_q < min_q)
							min_q <= temp_q;
					end
					if (!cnt_full) begin
						sum_q <= sum_q + {{(SUM_W-TEMP_BITS){temp_q[TEMP_BITS-1]}}, temp_q};
						cnt_q <= cnt_q + 1'b1;
					end
					// immediate fan cases; the in-range ratio goes to the divider
					if (fan_pres_q) begin
						if (!fan_valid)
							fan_pct_q <= '0;
						else if (rpm_full)
							fan_pct_q <= PCT_FULL;
					end
				end
			end
			if (cmd.mean_capture)
				mean_q <= sum_q[SUM_W-1] ? (QUO_W'(0) - div_quo) : div_quo;
			if (cmd.fan_capture)
				fan_pct_q <= div_quo[PCT_W-1:0];
		end
	end

	// divider operands
	always_comb begin
		sum_mag  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
		fan_prod = FAN_PROD_W'(rpm_q) * FAN_PROD_W'(PCT_FULL);
		case (cmd.div_sel)
			DIV_MEAN: begin
				div_dividend = DIVD_W'(sum_mag);
				div_divisor  = DIV_W'(cnt_q);
			end
			DIV_FAN: begin
				div_dividend = DIVD_W'(fan_prod);
				div_divisor  = DIV_W'(fan_max_q);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	tst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sts.count_zero = (cnt_q == '0);
		sts.fan_div    = ok_q && fan_pres_q && fan_valid && !rpm_full;
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_active_q <= active_q;
			res_status_q <= status_q;
			res_cur_q    <= cur_q;
			res_min_q    <= min_q;
			res_max_q    <= max_q;
			res_mean_q   <= mean_q;
			res_fan_q    <= fan_pct_q;
		end
	end

	assign active        = res_active_q;
	assign status        = res_status_q;
	assign current_milli = res_cur_q;
	assign min_milli     = res_min_q;
	assign max_milli     = res_max_q;
	assign mean_milli    = res_mean_q;
	assign fan_percent   = res_fan_q;

endmodule

`default_nettype wire

### rtl/tst_ctrl.sv
`default_nettype none

module tst_ctrl import tst_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire tst_sts_t sts,
	output tst_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_FAN_GO,
		ST_FAN_WAIT,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_MEAN;
		case (state_q)
			ST_IDLE:     cmd.load_in = in_valid;
			ST_UPDATE:   cmd.update  = 1'b1;
			ST_MEAN_GO:  cmd.div_start = !sts.count_zero;
			ST_MEAN_WAIT: cmd.mean_capture = sts.div_done;
			ST_FAN_GO: begin
				cmd.div_sel   = DIV_FAN;
				cmd.div_start = sts.fan_div;
			end
			ST_FAN_WAIT: begin
				cmd.div_sel     = DIV_FAN;
				cmd.fan_capture = sts.div_done;
			end
			ST_PUSH:     cmd.push = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.push || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_MEAN_GO;
				ST_MEAN_GO: begin
					state_q <= sts.count_zero ? ST_FAN_GO : ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (sts.div_done)
						state_q <= ST_FAN_GO;
				end
				ST_FAN_GO: begin
					state_q <= sts.fan_div ? ST_FAN_WAIT : ST_PUSH;
				end
				ST_FAN_WAIT: begin
					if (sts.div_done)
						state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_push_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending result");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_MEAN_WAIT || state_q == ST_FAN_WAIT))
		else $error("divider finished outside a wait state");

	a_accept_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_UPDATE))
		else $error("accepted request not applied next cycle");
`endif

endmodule

`default_nettype wire
